>>> hdl/oaht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-address hash table: table geometry,
// field widths, request and slot codes, and the slot word held in memory.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // Table geometry
    localparam int SLOTS      = 256;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_BITS + 1;
    // Set is rejected once used slots reach three quarters of the table
    localparam int USED_MAX   = (3 * SLOTS) / 4;

    // Stored key and value widths (compared / kept on these low bits)
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 64;

    // Transaction field widths
    localparam int TYPE_W     = 2;
    localparam int KEY_W      = 32;
    localparam int HASH_W     = 32;
    localparam int VALUE_W    = 64;
    localparam int LIVE_W     = 9;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_GET = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_SET = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_DEL = 2'd2;

    // Slot state codes
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_TOMB  = 2'd1;
    localparam logic [1:0] SLOT_LIVE  = 2'd2;

    typedef logic [TYPE_W-1:0]     req_type_t;
    typedef logic [KEY_W-1:0]      key_handle_t;
    typedef logic [HASH_W-1:0]     key_hash_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [LIVE_W-1:0]     live_t;
    typedef logic [SLOT_BITS-1:0]  slot_idx_t;
    typedef logic [CNT_W-1:0]      count_t;

    // One table entry as kept in memory
    typedef struct packed {
        logic [1:0]            state;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } slot_word_t;

    localparam int SLOT_WORD_W = $bits(slot_word_t);

endpackage
`default_nettype wire

>>> hdl/oaht_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_if
// Valid/ready channels of the hash table: the request channel and the
// response channel. A transaction moves on a clock edge with valid and ready.
// ----------------------------------------------------------------------------
interface oaht_req_if import oaht_pkg::*; ();
    logic        valid;
    logic        ready;
    req_type_t   req_type;
    key_handle_t key_handle;
    key_hash_t   key_hash;
    value_t      write_value;

    modport source (output valid, output req_type, output key_handle,
                    output key_hash, output write_value, input ready);
    modport sink   (input valid, input req_type, input key_handle,
                    input key_hash, input write_value, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   hit;
    logic   status;
    value_t read_value;
    live_t  live_entries;

    modport source (output valid, output hit, output status,
                    output read_value, output live_entries, input ready);
    modport sink   (input valid, input hit, input status,
                    input read_value, input live_entries, output ready);
endinterface
`default_nettype wire

>>> hdl/oaht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/open_address_hash_table.sv
`default_nettype none
// A probing request examines k slots (1..SLOTS) before its result is ready;
//   a request that needs no probe (zero key, unknown type, empty table on a
//   get or delete, full table on a set) goes straight to its result.
// One request is handled at a time (ready only while idle), bounded by the single read
//   port of the slot memory, which walks the probe sequence one slot per cycle.
// Reset: all slots read as empty at once (per-slot valid flops), counts zero.
// ----------------------------------------------------------------------------
// open_address_hash_table
// Fixed-size hash map with linear probing and tombstones. Gets, sets and
// deletes one key per transaction; sets are refused at three-quarter load.
// ----------------------------------------------------------------------------
module open_address_hash_table import oaht_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    oaht_req_if.sink   req,
    oaht_rsp_if.source rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]            state_reg,     state_next;
    slot_idx_t             cnt_reg,       cnt_next;
    slot_idx_t             cur_idx_reg,   cur_idx_next;
    slot_idx_t             iss_idx_reg,   iss_idx_next;
    logic                  tomb_seen_reg, tomb_seen_next;
    slot_idx_t             tomb_idx_reg,  tomb_idx_next;
    req_type_t             type_reg,      type_next;
    logic [KEY_BITS-1:0]   key_reg,       key_next;
    logic [VALUE_BITS-1:0] value_reg,     value_next;
    logic                  res_hit_reg,   res_hit_next;
    logic                  res_stat_reg,  res_stat_next;
    logic [VALUE_BITS-1:0] res_rd_reg,    res_rd_next;
    count_t                used_reg,      used_next;
    count_t                live_reg,      live_next;
    logic [SLOTS-1:0]      valid_reg;
    logic                  valid_q_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg;
    logic                  out_stat_reg;
    logic [VALUE_BITS-1:0] out_rd_reg;
    count_t                out_live_reg;
    logic                  out_load;

    slot_idx_t             rd_addr;
    slot_word_t            rd_word;
    logic [SLOT_WORD_W-1:0] rd_bits;
    logic [1:0]            slot_st;
    logic                  ram_we;
    slot_idx_t             ram_waddr;
    slot_word_t            ram_wdata;

    logic [KEY_BITS-1:0]   key_in;
    slot_idx_t             start_idx;
    logic                  term;
    logic                  found;
    logic                  have;
    logic                  pos_empty;
    slot_idx_t             pos;

    assign key_in    = req.key_handle[KEY_BITS-1:0];
    assign start_idx = req.key_hash[SLOT_BITS-1:0];
    assign req.ready = (state_reg == ST_IDLE);

    // Read address: start slot while idle, next probe slot while probing
    assign rd_addr = (state_reg == ST_IDLE) ? start_idx : iss_idx_reg;

    oaht_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_bits)
    );

    assign rd_word = slot_word_t'(rd_bits);
    // A never-written slot reads as empty
    assign slot_st = valid_q_reg ? rd_word.state : SLOT_EMPTY;

    // Control and probe datapath
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_idx_next   = cur_idx_reg;
        iss_idx_next   = iss_idx_reg;
        tomb_seen_next = tomb_seen_reg;
        tomb_idx_next  = tomb_idx_reg;
        type_next      = type_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        res_hit_next   = res_hit_reg;
        res_stat_next  = res_stat_reg;
        res_rd_next    = res_rd_reg;
        used_next      = used_reg;
        live_next      = live_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_idx_reg;
        ram_wdata      = '0;
        out_load       = 1'b0;
        term           = 1'b0;
        found          = 1'b0;
        have           = 1'b0;
        pos_empty      = 1'b0;
        pos            = cur_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    type_next      = req.req_type;
                    key_next       = key_in;
                    value_next     = req.write_value[VALUE_BITS-1:0];
                    cur_idx_next   = start_idx;
                    iss_idx_next   = start_idx + 1'b1;
                    cnt_next       = '0;
                    tomb_seen_next = 1'b0;
                    res_hit_next   = 1'b0;
                    res_stat_next  = 1'b0;
                    res_rd_next    = '0;
                    state_next     = ST_DONE;
                    if (key_in != '0)
                    begin
                        case (req.req_type)
                            REQ_GET, REQ_DEL:
                            begin
                                if (used_reg != '0)
                                begin
                                    state_next = ST_PROBE;
                                end
                            end
                            REQ_SET:
                            begin
                                if (used_reg >= count_t'(USED_MAX))
                                begin
                                    res_stat_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_PROBE;
                                end
                            end
                            default:
                            begin
                                state_next = ST_DONE;
                            end
                        endcase
                    end
                end
            end

            ST_PROBE:
            begin
                // Examine the slot whose data just returned
                case (slot_st)
                    SLOT_EMPTY:
                    begin
                        term      = 1'b1;
                        have      = 1'b1;
                        pos_empty = !tomb_seen_reg;
                        pos       = tomb_seen_reg ? tomb_idx_reg : cur_idx_reg;
                    end
                    SLOT_TOMB:
                    begin
                        if (!tomb_seen_reg)
                        begin
                            tomb_seen_next = 1'b1;
                            tomb_idx_next  = cur_idx_reg;
                        end
                    end
                    SLOT_LIVE:
                    begin
                        if (rd_word.key == key_reg)
                        begin
                            term  = 1'b1;
                            found = 1'b1;
                            have  = 1'b1;
                            pos   = cur_idx_reg;
                        end
                    end
                    default:
                    begin
                        term = 1'b0;
                    end
                endcase

                // Whole table walked without an empty slot
                if (!term && (cnt_reg == slot_idx_t'(SLOTS - 1)))
                begin
                    term = 1'b1;
                    have = tomb_seen_next;
                    pos  = tomb_idx_next;
                end

                cur_idx_next = iss_idx_reg;
                iss_idx_next = iss_idx_reg + 1'b1;
                cnt_next     = cnt_reg + 1'b1;

                if (term)
                begin
                    state_next = ST_DONE;
                    ram_waddr  = pos;
                    case (type_reg)
                        REQ_GET:
                        begin
                            if (found)
                            begin
                                res_hit_next = 1'b1;
                                res_rd_next  = rd_word.value;
                            end
                        end
                        REQ_SET:
                        begin
                            ram_wdata.state = SLOT_LIVE;
                            ram_wdata.key   = key_reg;
                            ram_wdata.value = value_reg;
                            if (found)
                            begin
                                ram_we = 1'b1;
                            end
                            else if (have)
                            begin
                                ram_we       = 1'b1;
                                res_hit_next = 1'b1;
                                live_next    = live_reg + 1'b1;
                                if (pos_empty)
                                begin
                                    used_next = used_reg + 1'b1;
                                end
                            end
                        end
                        REQ_DEL:
                        begin
                            if (found)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata.state = SLOT_TOMB;
                                ram_wdata.key   = rd_word.key;
                                ram_wdata.value = rd_word.value;
                                res_hit_next    = 1'b1;
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            res_hit_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            live_reg      <= '0;
            valid_reg     <= '0;
            valid_q_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            tomb_seen_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            live_reg      <= live_next;
            valid_q_reg   <= valid_reg[rd_addr];
            out_valid_reg <= out_valid_next;
            tomb_seen_reg <= tomb_seen_next;
            cnt_reg       <= cnt_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        cur_idx_reg  <= cur_idx_next;
        iss_idx_reg  <= iss_idx_next;
        tomb_idx_reg <= tomb_idx_next;
        type_reg     <= type_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        res_hit_reg  <= res_hit_next;
        res_stat_reg <= res_stat_next;
        res_rd_reg   <= res_rd_next;
        if (out_load)
        begin
            out_hit_reg  <= res_hit_reg;
            out_stat_reg <= res_stat_reg;
            out_rd_reg   <= res_rd_reg;
            out_live_reg <= live_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.status       = out_stat_reg;
    assign rsp.read_value   = VALUE_W'(out_rd_reg);
    assign rsp.live_entries = LIVE_W'(out_live_reg);

    // Tombstones are counted in used slots, so live keys never exceed them
    a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= used_reg)
        else $error("live key count exceeds used slot count");

    // Load check keeps used slots at or below the three-quarter limit
    a_used_limit: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= count_t'(USED_MAX))
        else $error("used slot count above load limit");

    // Memory is only written when a probe ends
    a_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_PROBE))
        else $error("slot write outside probe");

    // An accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("request accepted but block stayed idle");

    // A rejected set never reports a new key
    a_reject_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.status))
        else $error("hit and table-full reported together");

endmodule
`default_nettype wire
